// File: rtl/websocket_frame_receiver_top_assert.svh
// Assertion macros for the WebSocket frame receiver checker.
`ifndef WEBSOCKET_FRAME_RECEIVER_TOP_ASSERT_SVH
`define WEBSOCKET_FRAME_RECEIVER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define WFR_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("wfr check failed");

// Consequent must hold in the cycle after the antecedent.
`define WFR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("wfr check failed");

`endif

// File: rtl/wfr_pkg.sv
// Shared types and constants of the WebSocket frame receiver.
package wfr_pkg;

    localparam int PAYLOAD_BYTES = 32;
    localparam int LEN_W         = $clog2(PAYLOAD_BYTES + 1);
    localparam int IDX_W         = $clog2(PAYLOAD_BYTES);
    localparam int MASK_BYTES    = 4;
    localparam int HEAD_BYTES    = 6;
    localparam int HEAD_IDX_W    = $clog2(HEAD_BYTES);
    localparam int POINTER_BYTES = 6;
    localparam int KEY_BYTES     = 3;

    localparam logic [3:0] KIND_BINARY = 4'h2;
    localparam logic [3:0] KIND_CLOSE  = 4'h8;
    localparam logic [3:0] KIND_PING   = 4'h9;
    localparam logic [3:0] KIND_PONG   = 4'hA;

    localparam logic [7:0] TAG_POINTER = 8'h01;
    localparam logic [7:0] TAG_KEY     = 8'h02;
    localparam logic [6:0] LEN_EXT16   = 7'd126;

    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    typedef enum logic [2:0] {
        EV_POINTER = 3'd0,
        EV_KEY     = 3'd1,
        EV_PONG    = 3'd2,
        EV_CLOSE   = 3'd3,
        EV_ERROR   = 3'd4
    } t_event;

    typedef enum logic [3:0] {
        PH_HDR0 = 4'b0001,
        PH_HDR1 = 4'b0010,
        PH_MASK = 4'b0100,
        PH_DATA = 4'b1000
    } t_phase;

    typedef struct packed {
        logic       opcode;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        t_event             event_res;
        logic signed [15:0] pointer_x;
        logic signed [15:0] pointer_y;
        logic               pointer_pressed;
        logic [15:0]        key_code;
        logic [7:0]         reply_byte;
        logic               reply_has_byte;
        logic               last;
    } t_out_item;

endpackage

// File: rtl/websocket_frame_receiver_top.sv
// Top level of the WebSocket frame receiver: header parser, payload store, reply echo.
//
// Usage:
//   Input channel (i_valid, o_stall, i_item): one item per stream byte, or a restart
//   item that returns the parser to the first header byte without a result.
//   Output channel (o_valid, i_stall, o_res): result items; a run of results ends
//   with o_res.last set.
// Timing: a result appears in the output register in the cycle after the item causing it.
//   An echo of a ping or close starts when the final frame byte sets the echo busy flag,
//   then moves one byte per cycle while the receiver does not stall; each read goes through
//   the single read port of the payload store, whose read data is registered.
// Throughput: one item per cycle while bytes are parsed. During an echo the input is
//   stalled until its last byte moves to the output register, and while a result is held.
// Reset (synchronous, active low): parser back to the first header byte, output
//   empty, echo idle. The payload store and mask bytes are not cleared; every entry
//   is written within a frame before it is read.
// Receiver stall: the output register holds its item; the input is stalled as long
//   as a held result or a running echo would block the next one.
module websocket_frame_receiver_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  wfr_pkg::t_in_item  i_item,
    output logic               o_valid,
    input  logic               i_stall,
    output wfr_pkg::t_out_item o_res
);
    import wfr_pkg::*;

    // Parser state
    t_phase           r_phase,  n_phase;
    logic [3:0]       r_kind,   n_kind;
    logic [LEN_W-1:0] r_len,    n_len;
    logic [LEN_W-1:0] r_cnt,    n_cnt;
    logic [2:0]       r_mcnt,   n_mcnt;

    // Mask bytes and copies of the leading payload bytes for binary decoding
    logic [7:0] r_mask [MASK_BYTES];
    logic [7:0] r_head [HEAD_BYTES];

    // Payload store with registered read data
    logic [7:0] r_store [PAYLOAD_BYTES];
    logic [7:0] r_q;

    // Echo sequencer
    logic             r_busy,     n_busy;
    logic [LEN_W-1:0] r_echo_cnt, n_echo_cnt;
    logic [LEN_W-1:0] r_issue,    n_issue;
    t_event           r_echo_ev,  n_echo_ev;
    logic             r_rd_pend,  n_rd_pend;
    logic             r_q_last,   n_q_last;

    // Output register
    logic      r_out_valid, n_out_valid;
    t_out_item r_out,       n_out;

    logic             in_acc;
    logic [7:0]       unmasked;
    logic [7:0]       head_byte [HEAD_BYTES];
    logic             hdr_ok;
    logic             fin;
    logic [LEN_W-1:0] fin_cnt;
    logic             res_load;
    t_out_item        res_val;
    logic             move;
    logic             issue;
    logic             wr_store;
    logic             wr_mask;
    logic             wr_head;

    // Hold the input while an echo runs or a held result cannot drain.
    assign o_stall = r_busy || (r_out_valid && i_stall);
    assign in_acc  = i_valid && !o_stall;
    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    assign unmasked = i_item.rx_byte ^ r_mask[r_cnt[1:0]];

    // Merge the byte being written now so the frame can be decoded at its last byte.
    always_comb begin
        for (int k = 0; k < HEAD_BYTES; k++) begin
            head_byte[k] = (r_phase == PH_DATA && r_cnt == LEN_W'(k)) ? unmasked : r_head[k];
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_kind      = r_kind;
        n_len       = r_len;
        n_cnt       = r_cnt;
        n_mcnt      = r_mcnt;
        n_busy      = r_busy;
        n_echo_cnt  = r_echo_cnt;
        n_issue     = r_issue;
        n_echo_ev   = r_echo_ev;
        n_rd_pend   = r_rd_pend;
        n_q_last    = r_q_last;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        hdr_ok      = 1'b0;
        fin         = 1'b0;
        fin_cnt     = r_cnt;
        res_load    = 1'b0;
        res_val     = '0;
        wr_store    = 1'b0;
        wr_mask     = 1'b0;
        wr_head     = 1'b0;

        // Parse one accepted item.
        if (in_acc) begin
            if (i_item.opcode == OP_RESTART) begin
                n_phase = PH_HDR0;
                n_kind  = '0;
                n_len   = '0;
                n_cnt   = '0;
                n_mcnt  = '0;
            end else begin
                unique case (r_phase)
                    PH_HDR0: begin
                        hdr_ok = i_item.rx_byte[7] && (i_item.rx_byte[6:4] == 3'b000) &&
                                 (i_item.rx_byte[3:0] == KIND_BINARY ||
                                  i_item.rx_byte[3:0] == KIND_CLOSE  ||
                                  i_item.rx_byte[3:0] == KIND_PING   ||
                                  i_item.rx_byte[3:0] == KIND_PONG);
                        if (hdr_ok) begin
                            n_kind  = i_item.rx_byte[3:0];
                            n_phase = PH_HDR1;
                        end else begin
                            res_load          = 1'b1;
                            res_val.event_res = EV_ERROR;
                            res_val.last      = 1'b1;
                            n_phase           = PH_HDR0;
                            n_kind            = '0;
                            n_len             = '0;
                            n_cnt             = '0;
                            n_mcnt            = '0;
                        end
                    end
                    PH_HDR1: begin
                        n_cnt = '0;
                        if (!i_item.rx_byte[7] || i_item.rx_byte[6:0] >= LEN_EXT16 ||
                            i_item.rx_byte[6:0] > 7'(PAYLOAD_BYTES)) begin
                            res_load          = 1'b1;
                            res_val.event_res = EV_ERROR;
                            res_val.last      = 1'b1;
                            n_phase           = PH_HDR0;
                            n_kind            = '0;
                            n_len             = '0;
                            n_mcnt            = '0;
                        end else begin
                            n_len   = i_item.rx_byte[LEN_W-1:0];
                            n_mcnt  = '0;
                            n_phase = PH_MASK;
                        end
                    end
                    PH_MASK: begin
                        wr_mask = 1'b1;
                        n_mcnt  = r_mcnt + 3'd1;
                        if (n_mcnt >= 3'(MASK_BYTES)) begin
                            if (r_len == '0) begin
                                fin     = 1'b1;
                                fin_cnt = r_cnt;
                            end else begin
                                n_phase = PH_DATA;
                            end
                        end
                    end
                    PH_DATA: begin
                        wr_store = (r_cnt < LEN_W'(PAYLOAD_BYTES));
                        wr_head  = (r_cnt < LEN_W'(HEAD_BYTES));
                        n_cnt    = r_cnt + 1'b1;
                        if (n_cnt >= r_len) begin
                            fin     = 1'b1;
                            fin_cnt = n_cnt;
                        end
                    end
                    default: begin
                        n_phase = PH_HDR0;
                    end
                endcase
            end
        end

        // Complete the frame: decide its results and return to the first header byte.
        if (fin) begin
            n_phase = PH_HDR0;
            n_kind  = '0;
            n_len   = '0;
            n_cnt   = '0;
            n_mcnt  = '0;
            if (r_kind == KIND_CLOSE || r_kind == KIND_PING) begin
                if (fin_cnt == '0) begin
                    res_load          = 1'b1;
                    res_val.event_res = (r_kind == KIND_CLOSE) ? EV_CLOSE : EV_PONG;
                    res_val.last      = 1'b1;
                end else begin
                    n_busy     = 1'b1;
                    n_echo_cnt = fin_cnt;
                    n_issue    = '0;
                    n_echo_ev  = (r_kind == KIND_CLOSE) ? EV_CLOSE : EV_PONG;
                end
            end else if (r_kind == KIND_BINARY && fin_cnt != '0) begin
                if (head_byte[0] == TAG_POINTER && fin_cnt >= LEN_W'(POINTER_BYTES)) begin
                    res_load                = 1'b1;
                    res_val.event_res       = EV_POINTER;
                    res_val.pointer_x       = {head_byte[2], head_byte[1]};
                    res_val.pointer_y       = {head_byte[4], head_byte[3]};
                    res_val.pointer_pressed = |head_byte[5];
                    res_val.last            = 1'b1;
                end else if (head_byte[0] == TAG_KEY && fin_cnt >= LEN_W'(KEY_BYTES)) begin
                    res_load          = 1'b1;
                    res_val.event_res = EV_KEY;
                    res_val.key_code  = {head_byte[2], head_byte[1]};
                    res_val.last      = 1'b1;
                end
            end
        end

        // Echo: move read data to the output, issue the next read behind it.
        move  = r_rd_pend && (!r_out_valid || !i_stall);
        issue = r_busy && (r_issue < r_echo_cnt) && (!r_rd_pend || move);
        if (issue) begin
            n_issue   = r_issue + 1'b1;
            n_rd_pend = 1'b1;
            n_q_last  = ((r_issue + 1'b1) == r_echo_cnt);
        end else if (move) begin
            n_rd_pend = 1'b0;
        end
        if (move && r_q_last) begin
            n_busy = 1'b0;
        end

        // Output register
        if (res_load) begin
            n_out_valid = 1'b1;
            n_out       = res_val;
        end else if (move) begin
            n_out_valid          = 1'b1;
            n_out                = '0;
            n_out.event_res      = r_echo_ev;
            n_out.reply_byte     = r_q;
            n_out.reply_has_byte = 1'b1;
            n_out.last           = r_q_last;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HDR0;
            r_kind      <= '0;
            r_len       <= '0;
            r_cnt       <= '0;
            r_mcnt      <= '0;
            r_busy      <= 1'b0;
            r_echo_cnt  <= '0;
            r_issue     <= '0;
            r_echo_ev   <= EV_PONG;
            r_rd_pend   <= 1'b0;
            r_q_last    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_kind      <= n_kind;
            r_len       <= n_len;
            r_cnt       <= n_cnt;
            r_mcnt      <= n_mcnt;
            r_busy      <= n_busy;
            r_echo_cnt  <= n_echo_cnt;
            r_issue     <= n_issue;
            r_echo_ev   <= n_echo_ev;
            r_rd_pend   <= n_rd_pend;
            r_q_last    <= n_q_last;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (wr_mask) begin
            r_mask[r_mcnt[1:0]] <= i_item.rx_byte;
        end
        if (wr_head) begin
            r_head[r_cnt[HEAD_IDX_W-1:0]] <= unmasked;
        end
    end

    // Payload store: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_store) begin
            r_store[r_cnt[IDX_W-1:0]] <= unmasked;
        end
        if (issue) begin
            r_q <= r_store[r_issue[IDX_W-1:0]];
        end
    end

endmodule

// File: rtl/wfr_checker.sv
// Port-level checker of the WebSocket frame receiver and its bind.
`include "websocket_frame_receiver_top_assert.svh"

module wfr_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input wfr_pkg::t_in_item  i_item,
    input logic               o_valid,
    input logic               i_stall,
    input wfr_pkg::t_out_item o_res
);
    import wfr_pkg::*;

    logic restart_acc;
    logic single_ev;
    logic empty_reply;

    assign restart_acc = i_valid && !o_stall && (i_item.opcode == OP_RESTART);
    assign single_ev   = o_valid && (o_res.event_res == EV_POINTER ||
                                     o_res.event_res == EV_KEY ||
                                     o_res.event_res == EV_ERROR);
    assign empty_reply = o_valid && !o_res.reply_has_byte &&
                         (o_res.event_res == EV_PONG || o_res.event_res == EV_CLOSE);

    // A stalled result holds.
    `WFR_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_res))

    // Pointer, key and error results stand alone.
    `WFR_ASSERT_SAME(a_single_last, single_ev, o_res.last)

    // An empty reply stands alone.
    `WFR_ASSERT_SAME(a_empty_reply_last, empty_reply, o_res.last)

    // Input is held while a reply run is still going.
    `WFR_ASSERT_SAME(a_echo_stalls_in, o_valid && !o_res.last, o_stall)

    // A restart raises no result.
    `WFR_ASSERT_NEXT(a_restart_quiet, restart_acc, !o_valid)

endmodule

bind websocket_frame_receiver_top wfr_checker u_wfr_checker (.*);
